[rtl/core/assert_macros.svh]
// assertion macros used by mm3_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define MM3_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("murmur3 core check failed");

// clocked check that also holds during reset
`define MM3_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("murmur3 core reset check failed");

`endif

[rtl/core/mm3_pkg.sv]
// constants and helpers for the murmur3 byte stream hash core
package mm3_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ByteW = 8;
	localparam int unsigned PartW = 24;
	localparam int unsigned PosW  = 2;

	localparam logic [WordW-1:0] C1 = 32'hcc9e2d51;
	localparam logic [WordW-1:0] C2 = 32'h1b873593;
	localparam logic [WordW-1:0] CN = 32'he6546b64;
	localparam logic [WordW-1:0] F1 = 32'h85ebca6b;
	localparam logic [WordW-1:0] F2 = 32'hc2b2ae35;

	localparam logic [PosW-1:0] PosFull = 2'd3;

	function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x, input int unsigned r);
		rotl32 = (x << r) | (x >> (WordW - r));
	endfunction

endpackage

[rtl/core/mm3_stream_if.sv]
// valid/ready channel interfaces for message bytes and digests
interface mm3_byte_if;
	logic                            valid;
	logic                            ready;
	logic [mm3_pkg::ByteW-1:0]       data_byte;
	logic                            last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mm3_hash_if;
	logic                            valid;
	logic                            ready;
	logic [mm3_pkg::WordW-1:0]       hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

[rtl/core/murmur3_byte_stream_hash_core.sv]
// murmur3 x86 32-bit hash over a byte stream, seed zero, one shared multiplier
// Bytes arrive one per transaction on msg, with last_byte set on the final one, and the
// finished hash leaves on digest through an output register. A byte that does not
// complete a four-byte block is taken into the partial word. A byte that completes a
// block runs the steps take, c1 multiply, rotate and c2 multiply, hash mix, and msg.ready
// stays low until they are done. The final byte adds the tail scramble when the tail
// is not empty and then two finalizer multiplies and the load of the output register,
// which is held while an earlier digest is still waiting. The multiply steps share the
// single 32 by 32 multiplier; the hash mix uses shift and add instead.
module murmur3_byte_stream_hash_core (
	input  logic            clk,
	input  logic            arst_n,
	mm3_byte_if.sink        msg,
	mm3_hash_if.source      digest
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_MIX,
		ST_FIN1,
		ST_FIN2,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [mm3_pkg::WordW-1:0]       hash_q;
	logic [mm3_pkg::PartW-1:0]       partial_q;
	logic [mm3_pkg::PosW-1:0]        pos_q;
	logic [mm3_pkg::WordW-1:0]       len_q;
	logic [mm3_pkg::WordW-1:0]       work_q;
	logic                            block_q;
	logic                            last_q;
	logic                            out_valid_q;
	logic [mm3_pkg::WordW-1:0]       out_hash_q;

	logic [mm3_pkg::WordW-1:0]       word_in;
	logic [mm3_pkg::WordW-1:0]       mul_a;
	logic [mm3_pkg::WordW-1:0]       mul_b;
	logic [mm3_pkg::WordW-1:0]       mul_p;
	logic [mm3_pkg::WordW-1:0]       mix_rot;
	logic [mm3_pkg::WordW-1:0]       fin_pre;
	logic                            take;
	logic                            out_free;

	assign msg.ready         = (state_q == ST_IDLE);
	assign take              = msg.valid && msg.ready;
	assign out_free          = !out_valid_q || digest.ready;
	assign digest.valid      = out_valid_q;
	assign digest.hash_value = out_hash_q;

	// new byte lands little-endian at the current position
	assign word_in = {{(mm3_pkg::WordW - mm3_pkg::PartW){1'b0}}, partial_q}
		| ({{(mm3_pkg::WordW - mm3_pkg::ByteW){1'b0}}, msg.data_byte} << {pos_q, 3'b000});

	assign mix_rot = mm3_pkg::rotl32(hash_q ^ work_q, 13);
	assign fin_pre = (hash_q ^ len_q) ^ ((hash_q ^ len_q) >> 16);

	// shared multiplier, low word only
	always_comb begin
		unique case (state_q)
			ST_K1: begin
				mul_a = work_q;
				mul_b = mm3_pkg::C1;
			end
			ST_K2: begin
				mul_a = mm3_pkg::rotl32(work_q, 15);
				mul_b = mm3_pkg::C2;
			end
			ST_FIN1: begin
				mul_a = fin_pre;
				mul_b = mm3_pkg::F1;
			end
			ST_FIN2: begin
				mul_a = hash_q ^ (hash_q >> 13);
				mul_b = mm3_pkg::F2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hash_q      <= '0;
			partial_q   <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			work_q      <= '0;
			block_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_hash_q  <= '0;
		end else begin
			// the emit state reloads the output register itself
			if (out_valid_q && digest.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						len_q   <= len_q + 1'b1;
						work_q  <= word_in;
						last_q  <= msg.last_byte;
						block_q <= (pos_q == mm3_pkg::PosFull);
						if (pos_q == mm3_pkg::PosFull || msg.last_byte) begin
							state_q <= ST_K1;
						end else begin
							partial_q <= word_in[mm3_pkg::PartW-1:0];
							pos_q     <= pos_q + 1'b1;
						end
					end
				end
				ST_K1: begin
					work_q  <= mul_p;
					state_q <= ST_K2;
				end
				ST_K2: begin
					work_q  <= mul_p;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (block_q) begin
						// h = rotl(h ^ k, 13) * 5 + n, times five as shift and add
						hash_q    <= (mix_rot << 2) + mix_rot + mm3_pkg::CN;
						partial_q <= '0;
						pos_q     <= '0;
						state_q   <= last_q ? ST_FIN1 : ST_IDLE;
					end else begin
						hash_q  <= hash_q ^ work_q;
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					hash_q  <= mul_p;
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					hash_q  <= mul_p;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_hash_q  <= hash_q ^ (hash_q >> 16);
						hash_q      <= '0;
						partial_q   <= '0;
						pos_q       <= '0;
						len_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/mm3_checker.sv]
// port-level checks for the murmur3 core, bound to its top level
`include "assert_macros.svh"

module mm3_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      msg_valid,
	input logic                      msg_ready,
	input logic                      msg_last,
	input logic                      digest_valid,
	input logic                      digest_ready,
	input logic [mm3_pkg::WordW-1:0] digest_hash
);

	// a stalled digest keeps its valid and its value
	`MM3_ASSERT(a_digest_hold, digest_valid && !digest_ready |=> digest_valid && $stable(digest_hash))

	// the final byte starts the multiply steps, so no transaction is taken next cycle
	`MM3_ASSERT(a_busy_after_last, msg_valid && msg_ready && msg_last |=> !msg_ready)

	// a byte that is not final never raises a digest in the following cycle
	`MM3_ASSERT(a_no_early_digest, msg_valid && msg_ready && !msg_last |=> !$rose(digest_valid))

	// nothing is offered while reset is held
	`MM3_ASSERT_RST(a_reset_quiet, !arst_n |-> !digest_valid)

endmodule

bind murmur3_byte_stream_hash_core mm3_checker u_mm3_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_valid    (msg.valid),
	.msg_ready    (msg.ready),
	.msg_last     (msg.last_byte),
	.digest_valid (digest.valid),
	.digest_ready (digest.ready),
	.digest_hash  (digest.hash_value)
);
